// ----- rtl/jsesc_pkg.sv -----
// Shared types, character codes and UTF-8 classification helpers for the JSON string escaper.
package jsesc_pkg;

  localparam int unsigned MaxRun = 8;
  localparam int unsigned RunIdxW = 3;
  localparam int unsigned RunCntW = 4;

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowA   = 8'h61;

  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] Lead2Lo    = 8'hc2;
  localparam logic [7:0] Lead2Hi    = 8'hdf;
  localparam logic [7:0] Lead3Lo    = 8'he0;
  localparam logic [7:0] Lead3Hi    = 8'hef;
  localparam logic [7:0] Lead4Lo    = 8'hf0;
  localparam logic [7:0] Lead4Hi    = 8'hf4;
  localparam logic [7:0] LeadE0     = 8'he0;
  localparam logic [7:0] LeadEd     = 8'hed;
  localparam logic [7:0] LeadF0     = 8'hf0;
  localparam logic [7:0] LeadF4     = 8'hf4;
  localparam logic [7:0] MinAfterE0 = 8'ha0;
  localparam logic [7:0] MaxAfterEd = 8'h9f;
  localparam logic [7:0] MinAfterF0 = 8'h90;
  localparam logic [7:0] MaxAfterF4 = 8'h8f;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       string_start;
    logic       string_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_utf8;
  } out_word_t;

  // all output words caused by one input item
  typedef struct packed {
    logic [MaxRun-1:0][7:0] data;
    logic [MaxRun-1:0]      bad;
    logic [RunCntW-1:0]     count;
  } run_t;

  // second byte of a short escape, zero when the byte has none
  function automatic logic [7:0] esc_char(input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    unique case (b)
      8'h22:   r = 8'h22;
      8'h5c:   r = 8'h5c;
      8'h08:   r = 8'h62;
      8'h0c:   r = 8'h66;
      8'h0a:   r = 8'h6e;
      8'h0d:   r = 8'h72;
      8'h09:   r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CharZero + {4'h0, nib};
    end else begin
      r = CharLowA + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

  // sequence length from a lead byte, 0 when the byte cannot start one
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      r = 3'd2;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      r = 3'd3;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      r = 3'd4;
    end
    return r;
  endfunction

  // overlong, surrogate and beyond-range checks on the second byte
  function automatic logic second_bad(input logic [7:0] lead, input logic [7:0] b);
    return (lead == LeadE0 && b < MinAfterE0) || (lead == LeadEd && b > MaxAfterEd) ||
           (lead == LeadF0 && b < MinAfterF0) || (lead == LeadF4 && b > MaxAfterF4);
  endfunction

endpackage

// ----- rtl/jsesc_front.sv -----
// Front end: classifies each input word, tracks UTF-8 state and builds its output run.
module jsesc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jsesc_pkg::in_word_t in_i,
  input  logic                accept_i,
  output jsesc_pkg::run_t     run_o,
  output logic                run_valid_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      seq_len_q, seq_len_d;
  logic            skip_q, skip_d;

  always_comb begin
    logic [jsesc_pkg::MaxRun-1:0][7:0] data;
    logic [jsesc_pkg::MaxRun-1:0]      bad;
    logic [jsesc_pkg::RunCntW-1:0]     n;
    logic [7:0]                        b;
    logic [7:0]                        esc;
    logic [2:0]                        len;
    data       = '0;
    bad        = '0;
    n          = '0;
    b          = in_i.byte_value;
    esc        = jsesc_pkg::esc_char(b);
    len        = jsesc_pkg::lead_len(b);
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;
    skip_d     = skip_q;

    if (in_i.string_start) begin
      held_cnt_d = '0;
      seq_len_d  = '0;
      skip_d     = 1'b0;
      data[n[2:0]] = jsesc_pkg::CharQuote;
      n = n + 4'd1;
    end

    if (in_i.has_byte && !skip_d) begin
      if (seq_len_d == 3'd0) begin
        if (!b[7]) begin
          if (esc != 8'h00) begin
            data[n[2:0]] = jsesc_pkg::CharBslash;
            n = n + 4'd1;
            data[n[2:0]] = esc;
            n = n + 4'd1;
          end else if (b < 8'h20) begin
            data[n[2:0]] = jsesc_pkg::CharBslash;
            n = n + 4'd1;
            data[n[2:0]] = jsesc_pkg::CharU;
            n = n + 4'd1;
            data[n[2:0]] = jsesc_pkg::CharZero;
            n = n + 4'd1;
            data[n[2:0]] = jsesc_pkg::CharZero;
            n = n + 4'd1;
            data[n[2:0]] = jsesc_pkg::hex_char(b[7:4]);
            n = n + 4'd1;
            data[n[2:0]] = jsesc_pkg::hex_char(b[3:0]);
            n = n + 4'd1;
          end else begin
            data[n[2:0]] = b;
            n = n + 4'd1;
          end
        end else if (len == 3'd0) begin
          bad[n[2:0]] = 1'b1;
          n = n + 4'd1;
          skip_d = 1'b1;
        end else begin
          held_d[0]  = b;
          held_cnt_d = 2'd1;
          seq_len_d  = len;
        end
      end else if ((b & jsesc_pkg::ContMask) != jsesc_pkg::ContTag ||
                   (held_cnt_d == 2'd1 && jsesc_pkg::second_bad(held_q[0], b))) begin
        bad[n[2:0]] = 1'b1;
        n = n + 4'd1;
        held_cnt_d = '0;
        seq_len_d  = '0;
        skip_d     = 1'b1;
      end else if ({1'b0, held_cnt_d} + 3'd1 >= seq_len_d || held_cnt_d == 2'd3) begin
        // sequence complete: release the held bytes followed by this one
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_cnt_d) begin
            data[n[2:0]] = held_q[i];
            n = n + 4'd1;
          end
        end
        data[n[2:0]] = b;
        n = n + 4'd1;
        held_cnt_d = '0;
        seq_len_d  = '0;
      end else begin
        held_d[held_cnt_d] = b;
        held_cnt_d = held_cnt_d + 2'd1;
      end
    end

    if (in_i.string_end) begin
      if (!skip_d) begin
        if (seq_len_d != 3'd0) begin
          bad[n[2:0]] = 1'b1;
        end else begin
          data[n[2:0]] = jsesc_pkg::CharQuote;
        end
        n = n + 4'd1;
      end
      held_cnt_d = '0;
      seq_len_d  = '0;
      skip_d     = 1'b0;
    end

    run_o.data  = data;
    run_o.bad   = bad;
    run_o.count = n;
    run_valid_o = (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      seq_len_q  <= '0;
      skip_q     <= 1'b0;
    end else if (accept_i) begin
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
      skip_q     <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- rtl/jsesc_fifo.sv -----
// Short queue of output runs between the front end and the serializer.
module jsesc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  jsesc_pkg::run_t wr_data_i,
  input  logic            rd_i,
  output jsesc_pkg::run_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsesc_pkg::run_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/jsesc_back.sv -----
// Back end: walks the head run one output word per pop.
module jsesc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsesc_pkg::run_t      run_i,
  input  logic                 run_empty_i,
  output logic                 run_done_o,
  output jsesc_pkg::out_word_t out_o,
  output logic                 empty,
  input  logic                 pop
);

  logic [jsesc_pkg::RunIdxW-1:0] idx_q;
  logic                          last;

  assign last              = ({1'b0, idx_q} == run_i.count - 4'd1);
  assign empty             = run_empty_i;
  assign out_o.out_byte    = run_i.data[idx_q];
  assign out_o.bad_utf8    = run_i.bad[idx_q];
  assign out_o.last_of_run = last;
  assign run_done_o        = pop && !run_empty_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (pop && !run_empty_i) begin
      idx_q <= last ? '0 : idx_q + 1'b1;
    end
  end

endmodule

// ----- rtl/json_string_escaper_utf8_check_core.sv -----
// JSON string escaper with UTF-8 validation: takes one string byte per word and gives the
// quoted, escaped text one byte per word. An input word is taken every cycle while the run
// queue (FifoDepth entries, one per input word that yields output) has room; the result side
// gives one byte per cycle while popped, so a word that expands into an escape (up to eight
// result words with quotes) holds the result side and the queue absorbs the burst. Plain ASCII
// and completed UTF-8 sequences flow at one byte per cycle while popped. A held multi-byte
// sequence appears only when its final byte arrives and passes the checks; a bad sequence yields
// one bad_utf8 word and the rest of the string is dropped until string_end or string_start.
module json_string_escaper_utf8_check_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsesc_pkg::in_word_t  in_i,
  input  logic                 push,
  output logic                 full,
  output jsesc_pkg::out_word_t out_o,
  output logic                 empty,
  input  logic                 pop
);

  jsesc_pkg::run_t front_run, head_run;
  logic            front_valid, accept, q_full, q_empty, run_done;

  assign full   = q_full;
  assign accept = push && !q_full;

  jsesc_front u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .accept_i    (accept),
    .run_o       (front_run),
    .run_valid_o (front_valid)
  );

  jsesc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i      (accept && front_valid),
    .wr_data_i (front_run),
    .rd_i      (run_done),
    .rd_data_o (head_run),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  jsesc_back u_back (
    .clk_i,
    .rst_ni,
    .run_i       (head_run),
    .run_empty_i (q_empty),
    .run_done_o  (run_done),
    .out_o,
    .empty,
    .pop
  );

`ifndef SYNTHESIS
  // an error word is always the final word of its run and carries a zero byte
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.bad_utf8) |-> (out_o.last_of_run && out_o.out_byte == 8'h00))
    else $error("error word not last of run or carries data");

  // a run that is not finished keeps the result side non-empty
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_o.last_of_run) |=> !empty)
    else $error("run cut short");

  // a string start always yields at least its opening quote
  a_start_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_i.string_start) |=> !empty)
    else $error("string start produced no output");

  // queued runs are never empty
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (head_run.count != 4'd0 && head_run.count <= 4'd8))
    else $error("bad run length in queue");
`endif

endmodule

// ----- sim/escape_checker.sv -----
// Checker for the JSON string escaper: predicts escaped output words and compares them.
`timescale 1ns / 1ps

module escape_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsesc_pkg::in_word_t  in_i,
  input  logic                 push,
  input  logic                 full,
  input  jsesc_pkg::out_word_t out_o,
  input  logic                 empty,
  input  logic                 pop,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [7:0] EscB = "b";
  localparam logic [7:0] EscF = "f";
  localparam logic [7:0] EscN = "n";
  localparam logic [7:0] EscR = "r";
  localparam logic [7:0] EscT = "t";

  // predictor state
  logic [7:0] held_q [3];
  logic [1:0] held_num  = '0;
  logic [2:0] seq_need  = '0;
  logic       dropping  = 1'b0;

  jsesc_pkg::out_word_t expected_q [$];
  jsesc_pkg::out_word_t run_q [$];
  int                   failures = 0;

  task automatic put_out(input logic [7:0] b, input logic bad);
    jsesc_pkg::out_word_t w;
    w.out_byte    = b;
    w.last_of_run = 1'b0;
    w.bad_utf8    = bad;
    run_q = {run_q, w};
  endtask

  task automatic mark_bad_seq();
    put_out(8'h00, 1'b1);
    held_num = '0;
    seq_need = '0;
    dropping = 1'b1;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h61 + 8'(nib) - 8'd10);
  endfunction

  task automatic escape_ascii(input logic [7:0] b);
    logic [7:0] esc;
    case (b)
      8'h22:   esc = jsesc_pkg::CharQuote;
      8'h5c:   esc = jsesc_pkg::CharBslash;
      8'h08:   esc = EscB;
      8'h0c:   esc = EscF;
      8'h0a:   esc = EscN;
      8'h0d:   esc = EscR;
      8'h09:   esc = EscT;
      default: esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      put_out(jsesc_pkg::CharBslash, 1'b0);
      put_out(esc, 1'b0);
    end else if (b < 8'h20) begin
      put_out(jsesc_pkg::CharBslash, 1'b0);
      put_out(jsesc_pkg::CharU, 1'b0);
      put_out(jsesc_pkg::CharZero, 1'b0);
      put_out(jsesc_pkg::CharZero, 1'b0);
      put_out(hex_digit(b[7:4]), 1'b0);
      put_out(hex_digit(b[3:0]), 1'b0);
    end else begin
      put_out(b, 1'b0);
    end
  endtask

  task automatic take_utf8(input logic [7:0] b);
    logic [2:0] len;
    logic [7:0] lead;
    if (seq_need == 3'd0) begin
      len = 3'd0;
      if (b < 8'h80) begin
        escape_ascii(b);
      end else begin
        if (b >= jsesc_pkg::Lead2Lo && b <= jsesc_pkg::Lead2Hi) len = 3'd2;
        else if (b >= jsesc_pkg::Lead3Lo && b <= jsesc_pkg::Lead3Hi) len = 3'd3;
        else if (b >= jsesc_pkg::Lead4Lo && b <= jsesc_pkg::Lead4Hi) len = 3'd4;
        if (len == 3'd0) begin
          mark_bad_seq();
        end else begin
          held_q[0] = b;
          held_num  = 2'd1;
          seq_need  = len;
        end
      end
    end else if ((b & jsesc_pkg::ContMask) != jsesc_pkg::ContTag) begin
      mark_bad_seq();
    end else begin
      lead = held_q[0];
      if (held_num == 2'd1 &&
          ((lead == jsesc_pkg::LeadE0 && b < jsesc_pkg::MinAfterE0) ||
           (lead == jsesc_pkg::LeadEd && b > jsesc_pkg::MaxAfterEd) ||
           (lead == jsesc_pkg::LeadF0 && b < jsesc_pkg::MinAfterF0) ||
           (lead == jsesc_pkg::LeadF4 && b > jsesc_pkg::MaxAfterF4))) begin
        mark_bad_seq();
      end else if (int'(held_num) + 1 >= int'(seq_need)) begin
        for (int i = 0; i < int'(held_num); i++) put_out(held_q[i], 1'b0);
        put_out(b, 1'b0);
        held_num = '0;
        seq_need = '0;
      end else begin
        held_q[held_num] = b;
        held_num         = held_num + 2'd1;
      end
    end
  endtask

  task automatic predict_escape(input jsesc_pkg::in_word_t w);
    run_q.delete();
    if (w.string_start) begin
      held_num = '0;
      seq_need = '0;
      dropping = 1'b0;
      put_out(jsesc_pkg::CharQuote, 1'b0);
    end
    if (w.has_byte && !dropping) take_utf8(w.byte_value);
    if (w.string_end) begin
      if (!dropping) begin
        // a sequence cut off by the end replaces the closing quote
        if (seq_need != 3'd0) put_out(8'h00, 1'b1);
        else put_out(jsesc_pkg::CharQuote, 1'b0);
      end
      held_num = '0;
      seq_need = '0;
      dropping = 1'b0;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    expected_q = {expected_q, run_q};
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    jsesc_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if (push && !full) predict_escape(in_i);
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected word: byte=%h last=%b bad=%b",
                                 out_o.out_byte, out_o.last_of_run, out_o.bad_utf8));
        end else begin
          exp_w = expected_q.pop_front();
          if (out_o.out_byte !== exp_w.out_byte || out_o.last_of_run !== exp_w.last_of_run ||
              out_o.bad_utf8 !== exp_w.bad_utf8) begin
            note_failure($sformatf(
              "mismatch: exp byte=%h last=%b bad=%b, got byte=%h last=%b bad=%b",
              exp_w.out_byte, exp_w.last_of_run, exp_w.bad_utf8,
              out_o.out_byte, out_o.last_of_run, out_o.bad_utf8));
          end
        end
      end
    end
    pending_o    <= expected_q.size();
    fail_count_o <= failures;
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the JSON string escaper testbench: clock, reset, string stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  jsesc_pkg::in_word_t  in_w   = '0;
  logic                 push   = 1'b0;
  logic                 pop    = 1'b0;
  logic                 full;
  logic                 empty;
  jsesc_pkg::out_word_t out_w;
  int                   fail_count;
  int                   pending;

  // no random idling on either side while set
  logic      calm        = 1'b0;
  int        holds_asked = 0;
  int        holds_done  = 0;
  int        hold_left   = 0;

  always #2 clk_i = ~clk_i;

  json_string_escaper_utf8_check_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .push   (push),
    .full   (full),
    .out_o  (out_w),
    .empty  (empty),
    .pop    (pop)
  );

  escape_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_w),
    .push         (push),
    .full         (full),
    .out_o        (out_w),
    .empty        (empty),
    .pop          (pop),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      pop        <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= 79;
    end else begin
      pop <= calm || ($urandom_range(99) >= 16);
    end
  end

  int items_sent = 0;

  task automatic send_item(input logic [7:0] b, input logic has, input logic st,
                           input logic en);
    jsesc_pkg::in_word_t w;
    w.byte_value   = b;
    w.has_byte     = has;
    w.string_start = st;
    w.string_end   = en;
    while (!calm && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    in_w <= w;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [7:0] txt_q [$];
    logic [7:0] lead;
    logic [7:0] lo2;
    logic [7:0] hi2;
    int         units;
    int         len;
    int         pick;
    int         nstr;
    bit         sep_end;
    bit         drop_end;
    bit         no_start;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, all short escapes, \u00hh forms, longest run of eight words
    send_item(8'h5a, 1'b0, 1'b1, 1'b1);
    send_item(8'h22, 1'b1, 1'b1, 1'b0);
    send_item(8'h5c, 1'b1, 1'b0, 1'b0);
    send_item(8'h08, 1'b1, 1'b0, 1'b0);
    send_item(8'h0c, 1'b1, 1'b0, 1'b0);
    send_item(8'h0a, 1'b1, 1'b0, 1'b0);
    send_item(8'h0d, 1'b1, 1'b0, 1'b0);
    send_item(8'h09, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0, 1'b0);
    send_item(8'h1f, 1'b1, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b1, 1'b1);
    // highest code point, four bytes
    send_item(8'hf4, 1'b1, 1'b1, 1'b0);
    send_item(8'h8f, 1'b1, 1'b0, 1'b0);
    send_item(8'hbf, 1'b1, 1'b0, 1'b0);
    send_item(8'hbf, 1'b1, 1'b0, 1'b1);
    // bad lead: rest of string dropped, no closing quote
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    // sequence cut off by string end
    send_item(8'he0, 1'b1, 1'b1, 1'b0);
    send_item(8'ha0, 1'b1, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b1);
    // new string start while a sequence is pending
    send_item(8'hf0, 1'b1, 1'b1, 1'b0);
    send_item(8'hc3, 1'b1, 1'b1, 1'b0);
    send_item(8'ha9, 1'b1, 1'b0, 1'b1);
    wait_drained();

    nstr = 0;
    while (items_sent < 190) begin
      nstr++;
      if (nstr == 20) calm <= 1'b1;
      if (nstr == 35) calm <= 1'b0;

      if (nstr == 8) begin
        // long receiver hold-off while a burst of escapes keeps coming
        holds_asked <= holds_asked + 1;
        for (int i = 0; i < 12; i++)
          send_item(8'($urandom_range(31)), 1'b1, i == 0, i == 11);
        wait_drained();
        continue;
      end

      txt_q.delete();
      units = $urandom_range(6);
      for (int u = 0; u < units; u++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          txt_q = {txt_q, (($urandom_range(3) == 0) ? 8'($urandom_range(31))
                                                    : 8'($urandom_range(127)))};
        end else if (pick < 82) begin
          len = $urandom_range(4, 2);
          lo2 = 8'h80;
          hi2 = 8'hbf;
          case (len)
            2: lead = 8'($urandom_range(jsesc_pkg::Lead2Hi, jsesc_pkg::Lead2Lo));
            3: begin
              case ($urandom_range(2))
                0:       lead = jsesc_pkg::LeadE0;
                1:       lead = jsesc_pkg::LeadEd;
                default: lead = 8'($urandom_range(jsesc_pkg::Lead3Hi, jsesc_pkg::Lead3Lo));
              endcase
            end
            default: begin
              case ($urandom_range(2))
                0:       lead = jsesc_pkg::LeadF0;
                1:       lead = jsesc_pkg::LeadF4;
                default: lead = 8'($urandom_range(jsesc_pkg::Lead4Hi, jsesc_pkg::Lead4Lo));
              endcase
            end
          endcase
          if (lead == jsesc_pkg::LeadE0) lo2 = jsesc_pkg::MinAfterE0;
          if (lead == jsesc_pkg::LeadEd) hi2 = jsesc_pkg::MaxAfterEd;
          if (lead == jsesc_pkg::LeadF0) lo2 = jsesc_pkg::MinAfterF0;
          if (lead == jsesc_pkg::LeadF4) hi2 = jsesc_pkg::MaxAfterF4;
          txt_q = {txt_q, lead};
          txt_q = {txt_q, 8'($urandom_range(hi2, lo2))};
          for (int k = 2; k < len; k++) txt_q = {txt_q, 8'($urandom_range(8'hbf, 8'h80))};
          // now and then a sequence is cut short
          if ($urandom_range(9) == 0) void'(txt_q.pop_back());
        end else begin
          txt_q = {txt_q, 8'($urandom())};
        end
      end

      sep_end  = ($urandom_range(3) == 0);
      drop_end = ($urandom_range(11) == 0);
      no_start = ($urandom_range(19) == 0);
      if (txt_q.size() == 0) begin
        send_item(8'($urandom()), 1'b0, !no_start, !drop_end);
      end else begin
        foreach (txt_q[i]) begin
          send_item(txt_q[i], 1'b1, i == 0 && !no_start,
                    i == txt_q.size() - 1 && !sep_end && !drop_end);
          if ($urandom_range(24) == 0) send_item(8'($urandom()), 1'b0, 1'b0, 1'b0);
        end
        if (sep_end && !drop_end) send_item(8'($urandom()), 1'b0, 1'b0, 1'b1);
      end

      if (nstr == 15 || nstr == 40) wait_drained();
    end

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("json_string_escaper_utf8_check_core test passed");
    end else begin
      $display("json_string_escaper_utf8_check_core test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("json_string_escaper_utf8_check_core test failed");
    $finish;
  end

endmodule
